// ----- sv/twp_pkg.sv -----
// ----------------------------------------------------------------------------
// twp_pkg
// Shared types and constants of the trapezoid pulse evaluator.
// ----------------------------------------------------------------------------
package twp_pkg;

  localparam int unsigned CfgIdxBits = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_PERIOD      = 3'd0,
    REG_HEIGHT      = 3'd1,
    REG_HALF_WIDTH  = 3'd2,
    REG_RAMP_LENGTH = 3'd3,
    REG_CENTRE      = 3'd4
  } cfg_reg_e;

endpackage

// ----- sv/twp_mod_stage.sv -----
// ----------------------------------------------------------------------------
// twp_mod_stage
// One restoring step of the distance-modulo-period reduction.
// ----------------------------------------------------------------------------
module twp_mod_stage import twp_pkg::*; #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [TIME_BITS-1:0] period_i,
  input  logic                 valid_i,
  input  logic [TIME_BITS-1:0] rem_i,
  input  logic [TIME_BITS-1:0] dsh_i,
  output logic                 valid_o,
  output logic [TIME_BITS-1:0] rem_o,
  output logic [TIME_BITS-1:0] dsh_o
);

  logic [TIME_BITS:0]   trial;
  logic [TIME_BITS:0]   red;
  logic                 valid_q;
  logic [TIME_BITS-1:0] rem_q, dsh_q;

  // a zero period subtracts nothing, so the remainder ends as the distance
  assign trial = {rem_i, dsh_i[TIME_BITS-1]};
  assign red   = (trial >= {1'b0, period_i}) ? trial - {1'b0, period_i} : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= red[TIME_BITS-1:0];
      dsh_q <= {dsh_i[TIME_BITS-2:0], 1'b0};
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign dsh_o   = dsh_q;

endmodule

// ----- sv/twp_scale_stage.sv -----
// ----------------------------------------------------------------------------
// twp_scale_stage
// One height bit of the ramp level division floor(height * n / ramp).
// ----------------------------------------------------------------------------
module twp_scale_stage import twp_pkg::*; #(
  parameter int unsigned TIME_BITS  = 32,
  parameter int unsigned LEVEL_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  hbit_i,
  input  logic [TIME_BITS-2:0]  ramp_i,
  input  logic                  valid_i,
  input  logic [TIME_BITS-2:0]  n_i,
  input  logic [TIME_BITS-2:0]  acc_i,
  input  logic [LEVEL_BITS-1:0] q_i,
  input  logic                  is_ramp_i,
  input  logic [LEVEL_BITS-1:0] lvl_i,
  output logic                  valid_o,
  output logic [TIME_BITS-2:0]  n_o,
  output logic [TIME_BITS-2:0]  acc_o,
  output logic [LEVEL_BITS-1:0] q_o,
  output logic                  is_ramp_o,
  output logic [LEVEL_BITS-1:0] lvl_o
);

  logic [TIME_BITS:0]    acc2, e1, e2, acc_n;
  logic [1:0]            digit;
  logic                  valid_q, is_ramp_q;
  logic [TIME_BITS-2:0]  n_q, acc_q;
  logic [LEVEL_BITS-1:0] q_q, lvl_q;

  // acc stays below ramp, so the step adds at most two to the quotient
  always_comb begin
    acc2 = {1'b0, acc_i, 1'b0} + (hbit_i ? {2'b00, n_i} : '0);
    e1   = {2'b00, ramp_i};
    e2   = {1'b0, ramp_i, 1'b0};
    if (acc2 >= e2) begin
      acc_n = acc2 - e2;
      digit = 2'd2;
    end else if (acc2 >= e1) begin
      acc_n = acc2 - e1;
      digit = 2'd1;
    end else begin
      acc_n = acc2;
      digit = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q       <= n_i;
      acc_q     <= acc_n[TIME_BITS-2:0];
      q_q       <= {q_i[LEVEL_BITS-2:0], 1'b0} + {{(LEVEL_BITS-2){1'b0}}, digit};
      is_ramp_q <= is_ramp_i;
      lvl_q     <= lvl_i;
    end
  end

  assign valid_o   = valid_q;
  assign n_o       = n_q;
  assign acc_o     = acc_q;
  assign q_o       = q_q;
  assign is_ramp_o = is_ramp_q;
  assign lvl_o     = lvl_q;

endmodule

// ----- sv/trapezoid_pulse_evaluator.sv -----
// ----------------------------------------------------------------------------
// trapezoid_pulse_evaluator
// Level of a periodic trapezoidal pulse at a signed time position.
// ----------------------------------------------------------------------------
// Usage:
//   Send position requests on in_valid_i/in_ready_o/position_i; levels come
//   back in order on out_valid_o/out_ready_i/level_o, one per request.
//   Configure period, height, half width, ramp length and centre through
//   cfg_we_i/cfg_idx_i/cfg_data_i while no request is in flight.
// Pipeline: one distance stage, TIME_BITS modulo stages (one remainder bit
//   each), one region stage, LEVEL_BITS ramp division stages (one height
//   bit each) and the output register.
// Throughput: one request per cycle unless a stall holds the output.
// Reset: valid bits clear, config registers reset, data registers keep values.
// Stall: while a level waits with out_ready_i low the whole pipeline holds
//   and in_ready_o drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module trapezoid_pulse_evaluator import twp_pkg::*; #(
  parameter int unsigned TIME_BITS  = 32,
  parameter int unsigned LEVEL_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [CfgIdxBits-1:0]               cfg_idx_i,
  input  logic [((TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS)-1:0] cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [TIME_BITS-1:0]         position_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [LEVEL_BITS-1:0]               level_o
);

  localparam int unsigned T = TIME_BITS;
  localparam int unsigned L = LEVEL_BITS;

  logic [T-1:0] period_q;
  logic [L-1:0] height_q;
  logic [T-2:0] hw_q, ramp_q, centre_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= T'(1024);
      height_q <= L'(65535);
      hw_q     <= (T-1)'(128);
      ramp_q   <= (T-1)'(64);
      centre_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PERIOD:      period_q <= cfg_data_i[T-1:0];
        REG_HEIGHT:      height_q <= cfg_data_i[L-1:0];
        REG_HALF_WIDTH:  hw_q     <= cfg_data_i[T-2:0];
        REG_RAMP_LENGTH: ramp_q   <= cfg_data_i[T-2:0];
        REG_CENTRE:      centre_q <= cfg_data_i[T-2:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;
  logic [L-1:0] level_q;

  // whole pipeline moves unless the output holds a stalled level
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // distance stage
  logic signed [T:0] diff;
  logic [T:0]        dabs;
  logic              dv_q;
  logic [T-1:0]      d_q;

  assign diff = {position_i[T-1], position_i} - $signed({2'b00, centre_q});
  assign dabs = diff[T] ? -diff : diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= 1'b0;
    end else if (en) begin
      dv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q <= dabs[T-1:0];
    end
  end

  // modulo chain
  logic         mv   [T+1];
  logic [T-1:0] mrem [T+1];
  logic [T-1:0] mdsh [T+1];

  assign mv[0]   = dv_q;
  assign mrem[0] = '0;
  assign mdsh[0] = d_q;

  for (genvar k = 0; k < T; k++) begin : g_mod
    twp_mod_stage #(.TIME_BITS(T)) u_mod (
      .clk_i, .rst_ni, .en_i(en), .period_i(period_q),
      .valid_i(mv[k]), .rem_i(mrem[k]), .dsh_i(mdsh[k]),
      .valid_o(mv[k+1]), .rem_o(mrem[k+1]), .dsh_o(mdsh[k+1])
    );
  end

  // region stage
  logic [T:0]   r1, hw1, e1, p1, hwe, s;
  logic         ramp_d;
  logic [L-1:0] lvl_d;
  logic [T:0]   n_d;
  logic         rv_q, rramp_q;
  logic [L-1:0] rlvl_q;
  logic [T-2:0] rn_q;

  always_comb begin
    r1  = {1'b0, mrem[T]};
    hw1 = {2'b00, hw_q};
    e1  = {2'b00, ramp_q};
    p1  = {1'b0, period_q};
    hwe = hw1 + e1;
    s   = r1 + hwe;
    ramp_d = 1'b0;
    lvl_d  = height_q;
    n_d    = '0;
    if (r1 <= hw1) begin
      lvl_d = height_q;
    end else if (r1 <= hwe) begin
      ramp_d = 1'b1;
      n_d    = hwe - r1;
    end else if (s <= p1) begin
      lvl_d = '0;
    end else if (r1 + hw1 <= p1) begin
      ramp_d = 1'b1;
      n_d    = s - p1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else if (en) begin
      rv_q <= mv[T];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rramp_q <= ramp_d;
      rlvl_q  <= lvl_d;
      rn_q    <= n_d[T-2:0];
    end
  end

  // ramp division chain, most significant height bit first
  logic         sv   [L+1];
  logic [T-2:0] sn   [L+1];
  logic [T-2:0] sacc [L+1];
  logic [L-1:0] sq   [L+1];
  logic         sr   [L+1];
  logic [L-1:0] sl   [L+1];

  assign sv[0]   = rv_q;
  assign sn[0]   = rn_q;
  assign sacc[0] = '0;
  assign sq[0]   = '0;
  assign sr[0]   = rramp_q;
  assign sl[0]   = rlvl_q;

  for (genvar i = 0; i < L; i++) begin : g_scale
    twp_scale_stage #(.TIME_BITS(T), .LEVEL_BITS(L)) u_scale (
      .clk_i, .rst_ni, .en_i(en), .hbit_i(height_q[L-1-i]), .ramp_i(ramp_q),
      .valid_i(sv[i]), .n_i(sn[i]), .acc_i(sacc[i]), .q_i(sq[i]),
      .is_ramp_i(sr[i]), .lvl_i(sl[i]),
      .valid_o(sv[i+1]), .n_o(sn[i+1]), .acc_o(sacc[i+1]), .q_o(sq[i+1]),
      .is_ramp_o(sr[i+1]), .lvl_o(sl[i+1])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sv[L];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      level_q <= sr[L] ? sq[L] : sl[L];
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> level_o <= height_q)
    else $error("level above height");

  a_flat_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv_q && !rramp_q) |-> (rlvl_q == '0 || rlvl_q == height_q))
    else $error("flat region level is neither zero nor height");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(rv_q) && $stable(dv_q)))
    else $error("pipeline moved during stall");

endmodule
